/* rtl/sba_pkg.sv */
package sba_pkg;

    localparam int SLOT_W      = 8;
    localparam int CAP_W       = 9;
    localparam int KIND_W      = 3;
    localparam int WORD_W      = 64;
    localparam int BIT_SEL_W   = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TEST    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BAD     = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot_index;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] result_slot;
        logic              occupied;
        logic [CAP_W-1:0]  free_count;
    } t_rsp;

    typedef struct packed {
        logic [KIND_W-1:0] op;
        logic [SLOT_W-1:0] slot_index;
        logic              in_range;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_queue_head;

    typedef struct packed {
        logic             wipe;
        logic [CAP_W-1:0] cap;
    } t_wipe;

    // bits of a word whose global slot index lies below cap
    function automatic logic [WORD_W-1:0] cap_mask(logic [CAP_W-1:0] cap,
                                                   logic [CAP_W-1:0] base);
        logic [CAP_W-1:0] n;
        n = (cap > base) ? cap - base : '0;
        if (n >= CAP_W'(WORD_W)) begin
            return '1;
        end
        return (WORD_W'(1) << n[BIT_SEL_W-1:0]) - WORD_W'(1);
    endfunction

    // {found, index} of the lowest set bit: byte search, then bit search
    function automatic logic [BIT_SEL_W:0] lowest_set(logic [WORD_W-1:0] v);
        logic [7:0] nz;
        logic [2:0] b;
        logic [7:0] sel;
        logic [2:0] k;
        for (int i = 0; i < 8; i++) begin
            nz[i] = |v[8*i +: 8];
        end
        b = '0;
        for (int i = 7; i >= 0; i--) begin
            if (nz[i]) begin
                b = 3'(i);
            end
        end
        sel = v[8*b +: 8];
        k = '0;
        for (int i = 7; i >= 0; i--) begin
            if (sel[i]) begin
                k = 3'(i);
            end
        end
        return {|nz, b, k};
    endfunction

endpackage

/* rtl/sba_front.sv */
module sba_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  sba_pkg::t_req             i_req,
    input  logic [sba_pkg::CAP_W-1:0] i_cap,
    input  logic                      i_pop,
    output sba_pkg::t_queue_head      o_head
);
    import sba_pkg::*;

    t_entry     r_q [QUEUE_DEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_entry     cls_entry;
    logic       push;

    always_comb begin
        cls_entry.slot_index = i_req.slot_index;
        cls_entry.in_range   = {1'b0, i_req.slot_index} < i_cap;
        unique case (i_req.kind) inside
            KIND_CLEAR, KIND_ALLOC, KIND_RELEASE, KIND_TEST, KIND_FIND: begin
                cls_entry.op = i_req.kind;
            end
            default: begin
                cls_entry.op = KIND_BAD;
            end
        endcase
    end

    assign o_busy = (r_count == 2'(QUEUE_DEPTH));
    assign push   = i_start && !o_busy;

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.entry = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push  ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_entry;
        end
    end

endmodule

/* rtl/sba_back.sv */
module sba_back #(
    parameter int DEPTH = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sba_pkg::t_queue_head      i_head,
    output logic                      o_pop,
    input  logic [sba_pkg::CAP_W-1:0] i_cap,
    input  sba_pkg::t_wipe            i_wipe,
    output logic                      o_done,
    output sba_pkg::t_rsp             o_rsp
);
    import sba_pkg::*;

    localparam int WIW = (DEPTH > 128) ? 2 : 1;
    localparam int NW  = 2 ** WIW;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic [NW-1:0][WORD_W-1:0] r_bits;
    logic                      r_state, n_state;
    logic [WIW-1:0]            r_word, n_word;
    logic [KIND_W-1:0]         r_op, n_op;
    logic [SLOT_W-1:0]         r_idx, n_idx;
    logic                      r_occ, n_occ;
    logic [CAP_W-1:0]          r_free, n_free;
    logic                      r_done, n_done;
    t_rsp                      r_rsp, n_rsp;

    logic [WIW-1:0]       rd_addr;
    logic [WORD_W-1:0]    rd_word;
    logic                 wr_en;
    logic [WORD_W-1:0]    wr_word;
    logic                 wipe_all;
    logic [WIW-1:0]       head_word;
    logic [BIT_SEL_W-1:0] head_bit;
    logic                 head_occ;
    logic [CAP_W-1:0]     base;
    logic [WORD_W-1:0]    word_cap;
    logic [WORD_W-1:0]    start_mask;
    logic [WORD_W-1:0]    scan_mask;
    logic [BIT_SEL_W:0]   hit;
    logic                 last_word;

    assign head_word = i_head.entry.slot_index[BIT_SEL_W +: WIW];
    assign head_bit  = i_head.entry.slot_index[BIT_SEL_W-1:0];
    assign rd_addr   = (r_state == S_SCAN) ? r_word : head_word;
    assign rd_word   = r_bits[rd_addr];
    assign head_occ  = rd_word[head_bit] & i_head.entry.in_range;

    assign base       = CAP_W'({r_word, {BIT_SEL_W{1'b0}}});
    assign word_cap   = cap_mask(i_cap, base);
    assign start_mask = (r_word == r_idx[BIT_SEL_W +: WIW])
                      ? ~((WORD_W'(1) << r_idx[BIT_SEL_W-1:0]) - WORD_W'(1)) : '1;
    assign scan_mask  = (r_op == KIND_ALLOC) ? (~rd_word & word_cap)
                                             : (rd_word & word_cap & start_mask);
    assign hit        = lowest_set(scan_mask);
    assign last_word  = &r_word;

    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_op     = r_op;
        n_idx    = r_idx;
        n_occ    = r_occ;
        n_free   = r_free;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        o_pop    = 1'b0;
        wr_en    = 1'b0;
        wr_word  = rd_word;
        wipe_all = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop             = 1'b1;
                    n_done            = 1'b1;
                    n_rsp.status      = ST_OK;
                    n_rsp.result_slot = i_head.entry.slot_index;
                    n_rsp.occupied    = 1'b0;
                    n_op              = i_head.entry.op;
                    n_idx             = i_head.entry.slot_index;
                    unique case (i_head.entry.op)
                        KIND_CLEAR: begin
                            wipe_all = 1'b1;
                            n_free   = i_cap;
                        end
                        KIND_ALLOC: begin
                            n_done  = 1'b0;
                            n_state = S_SCAN;
                            n_word  = '0;
                        end
                        KIND_RELEASE: begin
                            if (head_occ) begin
                                n_rsp.occupied = 1'b1;
                                wr_en          = 1'b1;
                                wr_word        = rd_word & ~(WORD_W'(1) << head_bit);
                                if (r_free < i_cap) begin
                                    n_free = r_free + CAP_W'(1);
                                end
                            end else begin
                                n_rsp.status = ST_EMPTY;
                            end
                        end
                        KIND_TEST: begin
                            if (head_occ) begin
                                n_rsp.occupied = 1'b1;
                            end else begin
                                n_rsp.status = ST_EMPTY;
                            end
                        end
                        KIND_FIND: begin
                            n_rsp.occupied = head_occ;
                            if (i_head.entry.in_range) begin
                                n_done  = 1'b0;
                                n_state = S_SCAN;
                                n_word  = head_word;
                                n_occ   = head_occ;
                            end else begin
                                n_rsp.status = ST_MISS;
                            end
                        end
                        default: begin
                            n_rsp.status = ST_EMPTY;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_rsp.occupied = (r_op == KIND_ALLOC) ? 1'b0 : r_occ;
                if (hit[BIT_SEL_W]) begin
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                    n_rsp.status      = ST_OK;
                    n_rsp.result_slot = SLOT_W'({r_word, hit[BIT_SEL_W-1:0]});
                    if (r_op == KIND_ALLOC) begin
                        wr_en   = 1'b1;
                        wr_word = rd_word | (WORD_W'(1) << hit[BIT_SEL_W-1:0]);
                        if (r_free != '0) begin
                            n_free = r_free - CAP_W'(1);
                        end
                    end
                end else if (last_word) begin
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                    n_rsp.status      = ST_MISS;
                    n_rsp.result_slot = r_idx;
                end else begin
                    n_word = r_word + WIW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_rsp.free_count = n_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_free  <= CAP_W'(DEPTH);
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_free  <= n_free;
            if (i_wipe.wipe) begin
                r_bits <= '0;
                r_free <= i_wipe.cap;
            end else if (wipe_all) begin
                r_bits <= '0;
            end else if (wr_en) begin
                r_bits[rd_addr] <= wr_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_op   <= n_op;
        r_idx  <= n_idx;
        r_occ  <= n_occ;
        r_rsp  <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_free_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= i_cap)
        else $error("free count above capacity");

    a_free_matches_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_bits) + 32'(r_free)) == 32'(i_cap))
        else $error("free count disagrees with occupancy map");

    a_scan_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_op == KIND_ALLOC || r_op == KIND_FIND))
        else $error("scan running for a non-scanning request");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head.valid)
        else $error("pop from empty queue");

endmodule

/* rtl/slot_bitmap_allocator_top.sv */
// Slot bitmap allocator: occupancy map over up to 256 page slots plus a free count.
// Request channel: a transfer happens on a rising edge with start high and busy low;
// i_req carries kind and slot_index. busy is high while the two-entry request queue
// is full. Results come out on o_rsp for exactly one cycle, marked by o_done, one
// result per request, in request order. The receiver cannot stall the block.
// With the back end idle, clear, release, test, unknown kinds and out-of-range find-next
// finish in the idle state: the request is popped from the queue and o_done is registered.
// Allocate and find-next are popped the same way with a lookup, then scan the map
// one 64-bit word per cycle: allocate 1..4 words, find-next 1..4 from its start word on.
// Requests waiting in the queue add the back-end time of those ahead of them.
// Throughput: one request per cycle for the simple kinds while no scan runs; during a
// scan the back end takes no new request from the queue until the scan ends.
// Config port (APB): slot_capacity at byte address 0, 9 bits, capped at min(MAX_SLOTS,
// 256). Writing it empties the map and sets the free count to the capacity; write it
// only while no request is outstanding. pready is always high.
// Reset: map empty, capacity 256 (capped), free count equal to the capacity; the
// queue is empty and o_done low.
module slot_bitmap_allocator_top #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  sba_pkg::t_req       i_req,
    output logic                o_done,
    output sba_pkg::t_rsp       o_rsp
);
    import sba_pkg::*;

    localparam int DEPTH = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;

    logic [CAP_W-1:0] r_cap;
    logic [CAP_W-1:0] eff_cap;
    logic [CAP_W-1:0] wr_cap;
    logic             cfg_wr;
    t_wipe            wipe;
    t_queue_head      head;
    logic             pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && !paddr[2];
    assign eff_cap = (r_cap > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : r_cap;
    assign wr_cap  = (pwdata[CAP_W-1:0] > CAP_W'(DEPTH)) ? CAP_W'(DEPTH)
                                                        : pwdata[CAP_W-1:0];
    assign prdata  = paddr[2] ? 32'd0 : 32'(r_cap);

    assign wipe.wipe = cfg_wr;
    assign wipe.cap  = wr_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_W'(256);
        end else if (cfg_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    sba_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_req   (i_req),
        .i_cap   (eff_cap),
        .i_pop   (pop),
        .o_head  (head)
    );

    sba_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .i_cap   (eff_cap),
        .i_wipe  (wipe),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule
